FILE: hw/rtl/neumann_laplacian_stream_assert.svh
// Assertion macros for the neumann_laplacian_stream block.
// No dependencies; taken in by the top level with `include.
`ifndef NEUMANN_LAPLACIAN_STREAM_ASSERT_SVH
`define NEUMANN_LAPLACIAN_STREAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NLS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nls_pkg.sv
// Shared constants and types for the Neumann Laplacian stream.
// No dependencies.
package nls_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int WIDTH_REG_BITS = 13;
    localparam int ROW_BITS       = 16;
    localparam logic [WIDTH_REG_BITS-1:0] FRAME_WIDTH_RST = 13'd4096;
    localparam logic [ROW_BITS-1:0]       FRAME_HEIGHT_RST = 16'd4096;
    localparam int MIN_DIM = 3;

    // result range
    localparam int LAP_BITS = 19;
    localparam int LAP_MAX  = 262143;
    localparam int LAP_MIN  = -262144;

    typedef logic [ROW_BITS-1:0] row_t;

    // per-pixel neighborhood and result plan, computed at accept
    typedef struct packed {
        logic has_main;    // result for the pixel above
        logic has_side;    // last row: result for the pixel to the left
        logic has_corner;  // frame end: result for this pixel
        logic up_ok;
        logic left_ok;
        logic left2_ok;
        logic right_ok;
    } nls_flags_t;

    typedef struct packed {
        logic [2:0] pending;  // results still to send for the window item
        logic       load;     // a result moves into the output register
    } nls_status_t;

endpackage

FILE: hw/rtl/nls_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-before-write on an address collision
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/nls_window.sv
// Position counters, config registers, line stores and window register.
// Depends on nls_pkg and nls_ram.
module nls_window #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [nls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nls_pkg::CFG_DATA_BITS-1:0] cfg_wr_data,
    input  logic                              accept,
    input  logic [PIXEL_BITS-1:0]             pixel,
    output logic [PIXEL_BITS-1:0]             win_px,
    output logic [PIXEL_BITS-1:0]             win_center,
    output logic [PIXEL_BITS-1:0]             win_left,
    output logic [PIXEL_BITS-1:0]             win_right,
    output logic [PIXEL_BITS-1:0]             win_up,
    output logic [PIXEL_BITS-1:0]             win_prev1,
    output logic [PIXEL_BITS-1:0]             win_prev2,
    output logic [$clog2(MAX_WIDTH)-1:0]      win_col,
    output nls_pkg::row_t                     win_row,
    output nls_pkg::nls_flags_t               win_flags,
    output nls_pkg::nls_flags_t               flags_next
);
    import nls_pkg::*;

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WCMP_BITS = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_BITS) ?
                               $clog2(MAX_WIDTH + 1) : WIDTH_REG_BITS;

    logic [WIDTH_REG_BITS-1:0] frame_width_reg;
    row_t                      frame_height_reg;

    logic [COL_BITS-1:0] col_cnt_reg, col_cnt_next;
    row_t                row_cnt_reg, row_cnt_next;
    logic                sel_reg;
    logic [PIXEL_BITS-1:0] prev1_reg, prev2_reg, row0_reg;

    logic [PIXEL_BITS-1:0] px_reg, center_reg, left_reg, prev1_s_reg, prev2_s_reg;
    logic [COL_BITS-1:0]   col_s_reg;
    row_t                  row_s_reg;
    logic                  sel_s_reg;
    nls_flags_t            flags_reg;

    logic [WCMP_BITS-1:0] w_ext;
    logic [COL_BITS-1:0]  w_last;
    row_t                 h_last;
    logic                 row_end, last_row;
    logic [COL_BITS-1:0]  col_plus1;
    logic [PIXEL_BITS-1:0] center_next;

    logic [PIXEL_BITS-1:0] rd_a, rd_b, rd_prev_now;
    logic [COL_BITS-1:0]   raddr_a, raddr_b;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[WIDTH_REG_BITS-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective last column and row
    always_comb begin
        w_ext = WCMP_BITS'(frame_width_reg);
        if (w_ext < WCMP_BITS'(MIN_DIM)) begin
            w_last = COL_BITS'(MIN_DIM - 1);
        end else if (w_ext > WCMP_BITS'(MAX_WIDTH)) begin
            w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_BITS'(w_ext - WCMP_BITS'(1));
        end
        if (frame_height_reg < ROW_BITS'(MIN_DIM)) begin
            h_last = ROW_BITS'(MIN_DIM - 1);
        end else begin
            h_last = frame_height_reg - ROW_BITS'(1);
        end
    end

    assign row_end   = (col_cnt_reg >= w_last);
    assign last_row  = (row_cnt_reg >= h_last);
    assign col_plus1 = col_cnt_reg + COL_BITS'(1);

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (row_end) begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_BITS'(1);
        end else begin
            col_cnt_next = col_plus1;
        end
        flags_next.has_main   = (row_cnt_reg != '0);
        flags_next.has_side   = last_row && (col_cnt_reg != '0);
        flags_next.has_corner = last_row && row_end;
        flags_next.up_ok      = (row_cnt_reg >= ROW_BITS'(2));
        flags_next.left_ok    = (col_cnt_reg != '0);
        flags_next.left2_ok   = (col_cnt_reg >= COL_BITS'(2));
        flags_next.right_ok   = !row_end;
    end

    // store a holds the previous row when sel is 0; the other store is rewritten
    assign raddr_a = sel_reg ? col_cnt_reg : col_plus1;
    assign raddr_b = sel_reg ? col_plus1 : col_cnt_reg;

    nls_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_store_a (
        .clk     (aclk),
        .wr_en   (accept && sel_reg),
        .wr_addr (col_cnt_reg),
        .wr_data (pixel),
        .rd_en   (accept),
        .rd_addr (raddr_a),
        .rd_data (rd_a)
    );

    nls_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_store_b (
        .clk     (aclk),
        .wr_en   (accept && !sel_reg),
        .wr_addr (col_cnt_reg),
        .wr_data (pixel),
        .rd_en   (accept),
        .rd_addr (raddr_b),
        .rd_data (rd_b)
    );

    // the previous item's right-hand read is this item's center
    assign rd_prev_now = sel_reg ? rd_b : rd_a;
    assign center_next = (col_cnt_reg == '0) ? row0_reg : rd_prev_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            sel_reg     <= 1'b0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (row_end) begin
                sel_reg <= !sel_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev1_reg   <= pixel;
            prev2_reg   <= prev1_reg;
            if (col_cnt_reg == '0) begin
                row0_reg <= pixel;
            end
            px_reg      <= pixel;
            center_reg  <= center_next;
            left_reg    <= center_reg;
            prev1_s_reg <= prev1_reg;
            prev2_s_reg <= prev2_reg;
            col_s_reg   <= col_cnt_reg;
            row_s_reg   <= row_cnt_reg;
            sel_s_reg   <= sel_reg;
            flags_reg   <= flags_next;
        end
    end

    assign win_px     = px_reg;
    assign win_center = center_reg;
    assign win_left   = left_reg;
    assign win_right  = sel_s_reg ? rd_b : rd_a;
    assign win_up     = sel_s_reg ? rd_a : rd_b;
    assign win_prev1  = prev1_s_reg;
    assign win_prev2  = prev2_s_reg;
    assign win_col    = col_s_reg;
    assign win_row    = row_s_reg;
    assign win_flags  = flags_reg;

endmodule

FILE: hw/rtl/nls_emit.sv
// Result sequencer, Laplacian arithmetic and output register.
// Depends on nls_pkg.
module nls_emit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  nls_pkg::nls_flags_t             flags_next,
    input  logic [PIXEL_BITS-1:0]           win_px,
    input  logic [PIXEL_BITS-1:0]           win_center,
    input  logic [PIXEL_BITS-1:0]           win_left,
    input  logic [PIXEL_BITS-1:0]           win_right,
    input  logic [PIXEL_BITS-1:0]           win_up,
    input  logic [PIXEL_BITS-1:0]           win_prev1,
    input  logic [PIXEL_BITS-1:0]           win_prev2,
    input  logic [$clog2(MAX_WIDTH)-1:0]    win_col,
    input  nls_pkg::row_t                   win_row,
    input  nls_pkg::nls_flags_t             win_flags,
    output logic                            s_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [nls_pkg::LAP_BITS-1:0] m_laplace_value,
    output logic [$clog2(MAX_WIDTH)-1:0]    m_out_col,
    output nls_pkg::row_t                   m_out_row,
    output logic                            m_end_of_frame,
    output logic                            m_last_of_run,
    output nls_pkg::nls_status_t            status
);
    import nls_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int SW = PIXEL_BITS + 2;
    localparam int DW = PIXEL_BITS + 3;
    localparam int EW = (DW > LAP_BITS) ? DW : LAP_BITS;

    logic [2:0] pend_reg, pend_next, pend_low, pend_rest;
    logic       out_load, last;

    logic                  m_valid_reg;
    logic signed [LAP_BITS-1:0] lap_reg;
    logic [COL_BITS-1:0]   col_reg;
    row_t                  row_reg;
    logic                  eof_reg, last_reg;

    // operand selection
    logic [PIXEL_BITS-1:0] op_c, op_u, op_d, op_l, op_r;
    logic                  en_u, en_d, en_l, en_r;
    logic [COL_BITS-1:0]   res_col;
    row_t                  res_row;

    logic [SW-1:0]         sum, n_center;
    logic [2:0]            n;
    logic signed [DW-1:0]  diff;
    logic signed [EW-1:0]  diff_x;
    logic signed [LAP_BITS-1:0] lap_sat;

    assign pend_low  = pend_reg & (~pend_reg + 3'd1);
    assign pend_rest = pend_reg & ~pend_low;
    assign last      = (pend_rest == 3'b000);
    assign out_load  = (pend_reg != 3'b000) && (!m_valid_reg || m_ready);
    assign s_ready   = (pend_reg == 3'b000) || (out_load && last);

    always_comb begin
        pend_next = pend_reg;
        if (accept) begin
            pend_next = {flags_next.has_corner, flags_next.has_side, flags_next.has_main};
        end else if (out_load) begin
            pend_next = pend_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // main: pixel above; side: left neighbor on last row; corner: final pixel
    always_comb begin
        if (pend_reg[0]) begin
            op_c = win_center;
            op_u = win_up;    en_u = win_flags.up_ok;
            op_d = win_px;    en_d = 1'b1;
            op_l = win_left;  en_l = win_flags.left_ok;
            op_r = win_right; en_r = win_flags.right_ok;
            res_col = win_col;
            res_row = win_row - ROW_BITS'(1);
        end else if (pend_reg[1]) begin
            op_c = win_prev1;
            op_u = win_left;  en_u = 1'b1;
            op_d = win_px;    en_d = 1'b0;
            op_l = win_prev2; en_l = win_flags.left2_ok;
            op_r = win_px;    en_r = 1'b1;
            res_col = win_col - COL_BITS'(1);
            res_row = win_row;
        end else begin
            op_c = win_px;
            op_u = win_center; en_u = 1'b1;
            op_d = win_px;     en_d = 1'b0;
            op_l = win_prev1;  en_l = win_flags.left_ok;
            op_r = win_px;     en_r = 1'b0;
            res_col = win_col;
            res_row = win_row;
        end
    end

    always_comb begin
        sum = (en_u ? SW'(op_u) : '0) + (en_d ? SW'(op_d) : '0)
            + (en_l ? SW'(op_l) : '0) + (en_r ? SW'(op_r) : '0);
        n = 3'(en_u) + 3'(en_d) + 3'(en_l) + 3'(en_r);
        case (n)
            3'd1:    n_center = SW'(op_c);
            3'd2:    n_center = SW'(op_c) << 1;
            3'd3:    n_center = (SW'(op_c) << 1) + SW'(op_c);
            3'd4:    n_center = SW'(op_c) << 2;
            default: n_center = '0;
        endcase
        diff   = $signed({1'b0, sum}) - $signed({1'b0, n_center});
        diff_x = EW'(diff);
        if (diff_x > EW'(LAP_MAX)) begin
            lap_sat = LAP_BITS'(LAP_MAX);
        end else if (diff_x < EW'(LAP_MIN)) begin
            lap_sat = LAP_BITS'(LAP_MIN);
        end else begin
            lap_sat = LAP_BITS'(diff_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lap_reg  <= lap_sat;
            col_reg  <= res_col;
            row_reg  <= res_row;
            eof_reg  <= win_flags.has_corner && last;
            last_reg <= last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_laplace_value = lap_reg;
    assign m_out_col       = col_reg;
    assign m_out_row       = row_reg;
    assign m_end_of_frame  = eof_reg;
    assign m_last_of_run   = last_reg;
    assign status.pending  = pend_reg;
    assign status.load     = out_load;

endmodule

FILE: hw/rtl/neumann_laplacian_stream.sv
// Top level of the streaming 5-point Laplacian with Neumann borders.
// Depends on nls_pkg, nls_window, nls_emit and neumann_laplacian_stream_assert.svh.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-----------------------------------
//  input    | s_valid s_ready s_pixel        | one pixel request, raster order
//  result   | m_valid m_ready m_laplace_value| one result request with col/row,
//           | m_out_col m_out_row            | end-of-frame and last-of-run marks
//           | m_end_of_frame m_last_of_run   |
//  config   | cfg_wr_en cfg_index cfg_wr_data| register write, no wait
//
// Cycles: with m_ready high, one pixel per cycle on every row but the last; there
//   every pixel after the first of the row yields two results (three on the final
//   pixel), and the single result register paces input to one result per cycle.
// Path: the edge that takes a pixel request loads the window register (with
//   line-store read); its results then pass through the output register.
// Reset: counters, row-store select, pending results and m_valid clear; the
//   line stores are not cleared and are only used at entries already written.
// Stalls: the window register takes a new pixel while a result still waits
//   in the output register once the window has no results left; s_ready
//   falls while the window holds results that cannot all leave this cycle.
`include "neumann_laplacian_stream_assert.svh"

module neumann_laplacian_stream #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [nls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nls_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    // pixels in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [PIXEL_BITS-1:0]              s_pixel,
    // results out
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [nls_pkg::LAP_BITS-1:0] m_laplace_value,
    output logic [$clog2(MAX_WIDTH)-1:0]       m_out_col,
    output logic [nls_pkg::ROW_BITS-1:0]       m_out_row,
    output logic                               m_end_of_frame,
    output logic                               m_last_of_run
);
    import nls_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic accept;

    // window stage outputs
    logic [PIXEL_BITS-1:0] win_px, win_center, win_left, win_right;
    logic [PIXEL_BITS-1:0] win_up, win_prev1, win_prev2;
    logic [COL_BITS-1:0]   win_col;
    row_t                  win_row;
    nls_flags_t            win_flags;
    nls_flags_t            flags_next;
    nls_status_t           status;

    assign accept = s_valid && s_ready;

    // Counters and line stores; the pixel's neighborhood is registered here.
    nls_window #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .pixel       (s_pixel),
        .win_px      (win_px),
        .win_center  (win_center),
        .win_left    (win_left),
        .win_right   (win_right),
        .win_up      (win_up),
        .win_prev1   (win_prev1),
        .win_prev2   (win_prev2),
        .win_col     (win_col),
        .win_row     (win_row),
        .win_flags   (win_flags),
        .flags_next  (flags_next)
    );

    // Sends up to three results per window item, one per cycle while m_ready is high.
    nls_emit #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .flags_next      (flags_next),
        .win_px          (win_px),
        .win_center      (win_center),
        .win_left        (win_left),
        .win_right       (win_right),
        .win_up          (win_up),
        .win_prev1       (win_prev1),
        .win_prev2       (win_prev2),
        .win_col         (win_col),
        .win_row         (win_row),
        .win_flags       (win_flags),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_laplace_value (m_laplace_value),
        .m_out_col       (m_out_col),
        .m_out_row       (m_out_row),
        .m_end_of_frame  (m_end_of_frame),
        .m_last_of_run   (m_last_of_run),
        .status          (status)
    );

    // the frame's final result always closes its pixel's run
    `NLS_ASSERT_SAME(a_eof_closes_run, aclk, aresetn, m_valid && m_end_of_frame, m_last_of_run, "end of frame on a result that is not last of run")
    // a new pixel may only replace the window item as its last result leaves
    `NLS_ASSERT_SAME(a_accept_frees_window, aclk, aresetn, accept && (status.pending != 3'b000), status.load && $onehot(status.pending), "pixel taken while window results remain")
    // a loaded result is presented next cycle
    `NLS_ASSERT_NEXT(a_load_shows_result, aclk, aresetn, status.load, m_valid, "loaded result not presented")

endmodule
